FILE: src/ocse_pkg.sv
// ----------------------------------------------------------------------------
// ocse_pkg
// Shared types, constants and helpers for the eight-op cpu step engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ocse_pkg;

  localparam int MEM_WORDS = 65536;
  localparam int MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [31:0] MEM_LIMIT = 32'(MEM_WORDS);

  localparam int REG_COUNT = 8;
  localparam int REG_AW = $clog2(REG_COUNT);

  localparam int OP_LSB = 22;
  localparam int RA_LSB = 19;
  localparam int RB_LSB = 16;
  localparam int OFF_W = 16;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NOR  = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_RUN         = 2'd0,
    ST_HALT        = 2'd1,
    ST_DATA_FAULT  = 2'd2,
    ST_FETCH_FAULT = 2'd3
  } run_status_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } item_kind_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_DECODE,
    BK_EXEC,
    BK_MEMWB
  } back_state_t;

  typedef struct packed {
    item_kind_t  kind;
    logic        in_range;
    logic [15:0] addr;
    logic [31:0] word;
  } item_t;

  typedef struct packed {
    logic [31:0]       pc_now;
    run_status_t       run_status;
    logic [31:0]       executed_count;
    logic              reg_write_valid;
    logic [REG_AW-1:0] reg_write_index;
    logic [31:0]       reg_write_value;
    logic              mem_write_valid;
    logic [15:0]       mem_write_address;
    logic [31:0]       mem_write_value;
  } result_t;

  function automatic logic addr_ok(input logic [31:0] v);
    return !v[31] && (v < MEM_LIMIT);
  endfunction

endpackage

`default_nettype wire

FILE: src/ocse_front.sv
// ----------------------------------------------------------------------------
// ocse_front
// Input side: takes item beats, classifies them and holds them in a
// two-entry queue for the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ocse_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire logic            cmd,
  input  wire logic [15:0]     load_address,
  input  wire logic [31:0]     load_word,
  output logic                 item_valid,
  input  wire logic            item_pop,
  output ocse_pkg::item_t      item
);

  ocse_pkg::item_t entries [2];
  ocse_pkg::item_t in_item;
  logic [1:0] cnt;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       do_push;
  logic       do_pop;

  assign full       = (cnt == 2'd2);
  assign item_valid = (cnt != 2'd0);
  assign item       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_pop && item_valid;

  always_comb begin
    in_item.kind     = cmd ? ocse_pkg::KIND_STEP : ocse_pkg::KIND_LOAD;
    in_item.in_range = ({16'd0, load_address} < ocse_pkg::MEM_LIMIT);
    in_item.addr     = load_address;
    in_item.word     = load_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: src/ocse_back.sv
// ----------------------------------------------------------------------------
// ocse_back
// Execution back end: main memory, register file, program counter and the
// sequencer that loads words and steps instructions.
// ----------------------------------------------------------------------------
`default_nettype none

module ocse_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire ocse_pkg::item_t  item,
  output logic                  item_pop,
  input  wire logic             res_full,
  output logic                  res_push,
  output ocse_pkg::result_t     res
);

  ocse_pkg::back_state_t state;
  ocse_pkg::back_state_t state_next;
  logic [ocse_pkg::MEM_AW-1:0] clr_addr;

  logic [31:0] mem [ocse_pkg::MEM_WORDS];
  logic [31:0] mem_q;
  logic [ocse_pkg::MEM_AW-1:0] mem_addr;
  logic        mem_we;
  logic [31:0] mem_wdata;

  logic [31:0] rf [ocse_pkg::REG_COUNT];
  logic [31:0] rf_a;
  logic [31:0] rf_b;
  logic        rf_we;
  logic [ocse_pkg::REG_AW-1:0] rf_waddr;
  logic [31:0] rf_wdata;

  logic [31:0] pc;
  logic [31:0] pc_next;
  ocse_pkg::run_status_t status;
  ocse_pkg::run_status_t status_next;
  logic [31:0] count;
  logic [31:0] count_next;
  logic [31:0] ins;

  ocse_pkg::op_t op;
  logic [ocse_pkg::REG_AW-1:0] ra;
  logic [ocse_pkg::REG_AW-1:0] rb;
  logic [ocse_pkg::REG_AW-1:0] rd;
  logic [ocse_pkg::REG_AW-1:0] dec_ra;
  logic [ocse_pkg::REG_AW-1:0] dec_rb;
  logic [31:0] off_ext;
  logic [31:0] daddr;
  logic [31:0] pc_inc;
  logic        daddr_ok;
  logic        pc_ok;
  logic        start;

  assign op       = ocse_pkg::op_t'(ins[ocse_pkg::OP_LSB +: 3]);
  assign ra       = ins[ocse_pkg::RA_LSB +: ocse_pkg::REG_AW];
  assign rb       = ins[ocse_pkg::RB_LSB +: ocse_pkg::REG_AW];
  assign rd       = ins[ocse_pkg::REG_AW-1:0];
  assign dec_ra   = mem_q[ocse_pkg::RA_LSB +: ocse_pkg::REG_AW];
  assign dec_rb   = mem_q[ocse_pkg::RB_LSB +: ocse_pkg::REG_AW];
  assign off_ext  = {{(32-ocse_pkg::OFF_W){ins[ocse_pkg::OFF_W-1]}},
                     ins[ocse_pkg::OFF_W-1:0]};
  assign daddr    = rf_a + off_ext;
  assign pc_inc   = pc + 32'd1;
  assign daddr_ok = ocse_pkg::addr_ok(daddr);
  assign pc_ok    = ocse_pkg::addr_ok(pc);
  assign start    = item_valid && !res_full;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ocse_pkg::BK_CLEAR: begin
        if (clr_addr == ocse_pkg::MEM_AW'(ocse_pkg::MEM_WORDS - 1)) begin
          state_next = ocse_pkg::BK_IDLE;
        end
      end
      ocse_pkg::BK_IDLE: begin
        if (start && item.kind == ocse_pkg::KIND_STEP &&
            status == ocse_pkg::ST_RUN && pc_ok) begin
          state_next = ocse_pkg::BK_DECODE;
        end
      end
      ocse_pkg::BK_DECODE: begin
        state_next = ocse_pkg::BK_EXEC;
      end
      ocse_pkg::BK_EXEC: begin
        if (op == ocse_pkg::OP_LW && daddr_ok) begin
          state_next = ocse_pkg::BK_MEMWB;
        end else begin
          state_next = ocse_pkg::BK_IDLE;
        end
      end
      ocse_pkg::BK_MEMWB: begin
        state_next = ocse_pkg::BK_IDLE;
      end
      default: begin
        state_next = ocse_pkg::BK_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    mem_addr    = clr_addr;
    mem_we      = 1'b0;
    mem_wdata   = 32'd0;
    rf_we       = 1'b0;
    rf_waddr    = '0;
    rf_wdata    = 32'd0;
    pc_next     = pc;
    status_next = status;
    count_next  = count;
    item_pop    = 1'b0;
    res_push    = 1'b0;
    res.mem_write_valid   = 1'b0;
    res.mem_write_address = 16'd0;
    res.mem_write_value   = 32'd0;
    case (state)
      ocse_pkg::BK_CLEAR: begin
        mem_we = 1'b1;
      end
      ocse_pkg::BK_IDLE: begin
        if (start) begin
          item_pop = 1'b1;
          if (item.kind == ocse_pkg::KIND_LOAD) begin
            mem_we    = item.in_range;
            mem_addr  = item.addr[ocse_pkg::MEM_AW-1:0];
            mem_wdata = item.word;
            res_push  = 1'b1;
          end else if (status != ocse_pkg::ST_RUN) begin
            res_push = 1'b1;
          end else if (!pc_ok) begin
            status_next = ocse_pkg::ST_FETCH_FAULT;
            res_push    = 1'b1;
          end else begin
            mem_addr = pc[ocse_pkg::MEM_AW-1:0];
          end
        end
      end
      ocse_pkg::BK_DECODE: begin
        mem_addr = pc[ocse_pkg::MEM_AW-1:0];
      end
      ocse_pkg::BK_EXEC: begin
        count_next = count + 32'd1;
        pc_next    = pc_inc;
        res_push   = 1'b1;
        case (op)
          ocse_pkg::OP_ADD: begin
            rf_we    = 1'b1;
            rf_waddr = rd;
            rf_wdata = rf_a + rf_b;
          end
          ocse_pkg::OP_NOR: begin
            rf_we    = 1'b1;
            rf_waddr = rd;
            rf_wdata = ~(rf_a | rf_b);
          end
          ocse_pkg::OP_LW: begin
            if (!daddr_ok) begin
              status_next = ocse_pkg::ST_DATA_FAULT;
              pc_next     = pc;
            end else begin
              mem_addr = daddr[ocse_pkg::MEM_AW-1:0];
              res_push = 1'b0;
            end
          end
          ocse_pkg::OP_SW: begin
            if (!daddr_ok) begin
              status_next = ocse_pkg::ST_DATA_FAULT;
              pc_next     = pc;
            end else begin
              mem_we    = 1'b1;
              mem_addr  = daddr[ocse_pkg::MEM_AW-1:0];
              mem_wdata = rf_b;
              res.mem_write_valid   = 1'b1;
              res.mem_write_address = daddr[15:0];
              res.mem_write_value   = rf_b;
            end
          end
          ocse_pkg::OP_BEQ: begin
            if (rf_a == rf_b) begin
              pc_next = pc_inc + off_ext;
            end
          end
          ocse_pkg::OP_JALR: begin
            rf_we    = 1'b1;
            rf_waddr = rb;
            rf_wdata = pc_inc;
            pc_next  = (ra == rb) ? pc_inc : rf_a;
          end
          ocse_pkg::OP_HALT: begin
            status_next = ocse_pkg::ST_HALT;
          end
          default: begin
          end
        endcase
      end
      ocse_pkg::BK_MEMWB: begin
        rf_we    = 1'b1;
        rf_waddr = rb;
        rf_wdata = mem_q;
        res_push = 1'b1;
      end
      default: begin
      end
    endcase
    res.pc_now          = pc_next;
    res.run_status      = status_next;
    res.executed_count  = count_next;
    res.reg_write_valid = rf_we;
    res.reg_write_index = rf_waddr;
    res.reg_write_value = rf_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ocse_pkg::BK_CLEAR;
      clr_addr <= '0;
      pc       <= 32'd0;
      status   <= ocse_pkg::ST_RUN;
      count    <= 32'd0;
    end else begin
      state  <= state_next;
      pc     <= pc_next;
      status <= status_next;
      count  <= count_next;
      if (state == ocse_pkg::BK_CLEAR) begin
        clr_addr <= clr_addr + ocse_pkg::MEM_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ocse_pkg::BK_DECODE) begin
      ins  <= mem_q;
      rf_a <= rf[dec_ra];
      rf_b <= rf[dec_rb];
    end
  end

  // main memory, one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_q <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ocse_pkg::REG_COUNT; i++) begin
        rf[i] <= 32'd0;
      end
    end else if (rf_we) begin
      rf[rf_waddr] <= rf_wdata;
    end
  end

endmodule

`default_nettype wire

FILE: src/ocse_res_q.sv
// ----------------------------------------------------------------------------
// ocse_res_q
// Two-entry result queue between the back end and the result ports.
// ----------------------------------------------------------------------------
`default_nettype none

module ocse_res_q (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire ocse_pkg::result_t  din,
  output logic                    full,
  input  wire logic               pop,
  output logic                    empty,
  output ocse_pkg::result_t       dout
);

  ocse_pkg::result_t entries [2];
  logic [1:0] cnt;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign dout    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

FILE: src/eight_op_cpu_step_engine_unit.sv
// ----------------------------------------------------------------------------
// eight_op_cpu_step_engine_unit
// Word-addressed eight-instruction processor that loads memory words and
// executes one instruction per step beat, reporting state and writes.
// ----------------------------------------------------------------------------
// After reset the block clears its 65536-word main memory one word per
// cycle, so full stays high once the two-entry input queue fills and no
// result appears until the clear is done. Beats are taken only in the idle
// state, where a load or a step on a stopped or faulting pc completes; a
// normal step passes through fetch, register read and execute, and load
// word adds a write-back state, as its read uses the single main memory port.
// Inputs and results each pass through a two-entry queue, so each side can
// keep moving for up to two beats while the other stalls.
`default_nettype none

module eight_op_cpu_step_engine_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               cmd,
  input  wire logic [15:0]        load_address,
  input  wire logic [31:0]        load_word,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [31:0]      pc_now,
  output logic [1:0]              run_status,
  output logic [31:0]             executed_count,
  output logic                    reg_write_valid,
  output logic [2:0]              reg_write_index,
  output logic signed [31:0]      reg_write_value,
  output logic                    mem_write_valid,
  output logic [15:0]             mem_write_address,
  output logic signed [31:0]      mem_write_value
);

  ocse_pkg::item_t   item;
  logic              item_valid;
  logic              item_pop;
  ocse_pkg::result_t res_in;
  ocse_pkg::result_t res_out;
  logic              res_push;
  logic              res_full;

  ocse_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .load_address (load_address),
    .load_word    (load_word),
    .item_valid   (item_valid),
    .item_pop     (item_pop),
    .item         (item)
  );

  ocse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in)
  );

  ocse_res_q u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .empty (empty),
    .dout  (res_out)
  );

  assign pc_now            = res_out.pc_now;
  assign run_status        = res_out.run_status;
  assign executed_count    = res_out.executed_count;
  assign reg_write_valid   = res_out.reg_write_valid;
  assign reg_write_index   = res_out.reg_write_index;
  assign reg_write_value   = res_out.reg_write_value;
  assign mem_write_valid   = res_out.mem_write_valid;
  assign mem_write_address = res_out.mem_write_address;
  assign mem_write_value   = res_out.mem_write_value;

endmodule

`default_nettype wire

FILE: tb/sv/ocse_step_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ocse_step_checker
// Watches both queue channels of the step engine. Every accepted input beat
// is run through an instruction-level model of the machine, and the report
// it produces is queued. Each popped result is compared field by field with
// the oldest queued report. The model's pc and registers are also exported
// so the stimulus can build programs that keep the machine running.
// ----------------------------------------------------------------------------
module ocse_step_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic                                 full,
  input  logic                                 cmd,
  input  logic [15:0]                          load_address,
  input  logic [31:0]                          load_word,
  input  logic                                 empty,
  input  logic                                 pop,
  input  logic [31:0]                          pc_now,
  input  logic [1:0]                           run_status,
  input  logic [31:0]                          executed_count,
  input  logic                                 reg_write_valid,
  input  logic [2:0]                           reg_write_index,
  input  logic [31:0]                          reg_write_value,
  input  logic                                 mem_write_valid,
  input  logic [15:0]                          mem_write_address,
  input  logic [31:0]                          mem_write_value,
  output int                                   fail_count,
  output int                                   pending,
  output logic [31:0]                          arch_pc,
  output logic [ocse_pkg::REG_COUNT-1:0][31:0] arch_regs
);

  logic [31:0]           mem_img [ocse_pkg::MEM_WORDS];
  logic [31:0]           arch_count;
  ocse_pkg::run_status_t arch_status;
  ocse_pkg::result_t     report_queue [$];
  ocse_pkg::result_t     report;
  ocse_pkg::result_t     oldest;

  function automatic logic in_range(input logic [31:0] v);
    return !v[31] && (v < ocse_pkg::MEM_LIMIT);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic advance_machine(input logic kind, input logic [15:0] addr_in,
                                 input logic [31:0] word_in,
                                 output ocse_pkg::result_t rep);
    logic [31:0]   ins;
    logic [31:0]   off;
    logic [31:0]   nxt;
    logic [31:0]   ea;
    logic [2:0]    ra;
    logic [2:0]    rb;
    ocse_pkg::op_t op;
    rep = '0;
    if (kind == ocse_pkg::KIND_LOAD) begin
      if (32'(addr_in) < ocse_pkg::MEM_LIMIT) begin
        mem_img[addr_in[ocse_pkg::MEM_AW-1:0]] = word_in;
      end
    end else if (arch_status == ocse_pkg::ST_RUN) begin
      if (!in_range(arch_pc)) begin
        arch_status = ocse_pkg::ST_FETCH_FAULT;
      end else begin
        ins = mem_img[arch_pc[ocse_pkg::MEM_AW-1:0]];
        op  = ocse_pkg::op_t'(ins[ocse_pkg::OP_LSB +: 3]);
        ra  = ins[ocse_pkg::RA_LSB +: 3];
        rb  = ins[ocse_pkg::RB_LSB +: 3];
        off = {{16{ins[ocse_pkg::OFF_W-1]}}, ins[ocse_pkg::OFF_W-1:0]};
        nxt = arch_pc + 32'd1;
        arch_count = arch_count + 32'd1;
        case (op)
          ocse_pkg::OP_ADD: begin
            rep.reg_write_valid = 1'b1;
            rep.reg_write_index = ins[2:0];
            rep.reg_write_value = arch_regs[ra] + arch_regs[rb];
          end
          ocse_pkg::OP_NOR: begin
            rep.reg_write_valid = 1'b1;
            rep.reg_write_index = ins[2:0];
            rep.reg_write_value = ~(arch_regs[ra] | arch_regs[rb]);
          end
          ocse_pkg::OP_LW: begin
            ea = arch_regs[ra] + off;
            if (!in_range(ea)) begin
              arch_status = ocse_pkg::ST_DATA_FAULT;
              nxt = arch_pc;
            end else begin
              rep.reg_write_valid = 1'b1;
              rep.reg_write_index = rb;
              rep.reg_write_value = mem_img[ea[ocse_pkg::MEM_AW-1:0]];
            end
          end
          ocse_pkg::OP_SW: begin
            ea = arch_regs[ra] + off;
            if (!in_range(ea)) begin
              arch_status = ocse_pkg::ST_DATA_FAULT;
              nxt = arch_pc;
            end else begin
              rep.mem_write_valid   = 1'b1;
              rep.mem_write_address = ea[15:0];
              rep.mem_write_value   = arch_regs[rb];
              mem_img[ea[ocse_pkg::MEM_AW-1:0]] = arch_regs[rb];
            end
          end
          ocse_pkg::OP_BEQ: begin
            if (arch_regs[ra] == arch_regs[rb]) nxt = arch_pc + 32'd1 + off;
          end
          ocse_pkg::OP_JALR: begin
            // link lands first, so ra equal to rb jumps to pc + 1
            arch_regs[rb] = nxt;
            rep.reg_write_valid = 1'b1;
            rep.reg_write_index = rb;
            rep.reg_write_value = nxt;
            nxt = arch_regs[ra];
          end
          ocse_pkg::OP_HALT: arch_status = ocse_pkg::ST_HALT;
          default: ;
        endcase
        if (rep.reg_write_valid) arch_regs[rep.reg_write_index] = rep.reg_write_value;
        arch_pc = nxt;
      end
    end
    rep.pc_now         = arch_pc;
    rep.run_status     = arch_status;
    rep.executed_count = arch_count;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ocse_pkg::MEM_WORDS; i++) mem_img[i] = '0;
      arch_pc = '0;
      arch_regs = '0;
      arch_status = ocse_pkg::ST_RUN;
      arch_count = '0;
      fail_count = 0;
      report_queue.delete();
    end else begin
      if (pop && !empty) begin
        if (report_queue.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual pc %0h", $time, pc_now);
          fail_count++;
        end else begin
          oldest = report_queue.pop_front();
          check_field("pc_now", oldest.pc_now, pc_now);
          check_field("run_status", 32'(oldest.run_status), 32'(run_status));
          check_field("executed_count", oldest.executed_count, executed_count);
          check_field("reg_write_valid", 32'(oldest.reg_write_valid), 32'(reg_write_valid));
          check_field("reg_write_index", 32'(oldest.reg_write_index), 32'(reg_write_index));
          check_field("reg_write_value", oldest.reg_write_value, reg_write_value);
          check_field("mem_write_valid", 32'(oldest.mem_write_valid), 32'(mem_write_valid));
          check_field("mem_write_address", 32'(oldest.mem_write_address),
                      32'(mem_write_address));
          check_field("mem_write_value", oldest.mem_write_value, mem_write_value);
        end
      end
      if (push && !full) begin
        advance_machine(cmd, load_address, load_word, report);
        report_queue.push_back(report);
      end
    end
    pending = report_queue.size();
  end

endmodule

FILE: tb/sv/tb_eight_op_cpu_step_engine_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_eight_op_cpu_step_engine_unit
// Drives the step engine with small programs written one instruction ahead
// of the pc: each instruction beat is a memory load at the pc followed by a
// step. Operands are chosen from the checker's view of the registers so the
// machine keeps running through every opcode until one final halt or fault.
// Both sides idle at random, and the result side holds off once for a long
// stretch so the input stalls. The checker module does all comparing.
// ----------------------------------------------------------------------------
module tb_eight_op_cpu_step_engine_unit;

  localparam int RANDOM_BEATS = 1600;

  logic                                 clk;
  logic                                 rst;
  logic                                 push;
  logic                                 full;
  logic                                 cmd;
  logic [15:0]                          load_address;
  logic [31:0]                          load_word;
  logic                                 empty;
  logic                                 pop;
  logic signed [31:0]                   pc_now;
  logic [1:0]                           run_status;
  logic [31:0]                          executed_count;
  logic                                 reg_write_valid;
  logic [2:0]                           reg_write_index;
  logic signed [31:0]                   reg_write_value;
  logic                                 mem_write_valid;
  logic [15:0]                          mem_write_address;
  logic signed [31:0]                   mem_write_value;
  int                                   fail_count;
  int                                   pending;
  logic [31:0]                          arch_pc;
  logic [ocse_pkg::REG_COUNT-1:0][31:0] arch_regs;

  int beats_sent;
  bit send_calm;

  eight_op_cpu_step_engine_unit i_dut (.*);

  ocse_step_checker i_chk (.*);

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #6_000_000;
    $display("** eight_op_cpu_step_engine_unit: FAILED **");
    $finish;
  end

  function automatic logic reachable(input logic [31:0] v);
    return !v[31] && (v < ocse_pkg::MEM_LIMIT);
  endfunction

  function automatic logic [31:0] encode(input ocse_pkg::op_t op, input logic [2:0] ra,
                                         input logic [2:0] rb, input logic [15:0] low);
    return {7'($urandom), op, ra, rb, low};
  endfunction

  function automatic logic [15:0] pick_offset();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 64) - 32);
      1: return ($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_data();
    return ($urandom_range(0, 1) == 1) ? $urandom :
           32'($urandom_range(0, ocse_pkg::MEM_WORDS - 1));
  endfunction

  task automatic send(input ocse_pkg::item_kind_t kind, input logic [15:0] addr,
                      input logic [31:0] word);
    int gap;
    if (beats_sent % 64 == 0) send_calm = ($urandom_range(0, 2) == 0);
    gap = send_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    cmd = kind;
    load_address = addr;
    load_word = word;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  // instruction for the current pc that keeps the machine running
  task automatic build_instr(input ocse_pkg::op_t want, input bit same_ab,
                             output logic [31:0] ins);
    ocse_pkg::op_t op;
    logic [2:0]    ra;
    logic [2:0]    rb;
    logic [15:0]   off;
    logic [31:0]   dest;
    bit            found;
    op = want;
    if (arch_pc == ocse_pkg::MEM_LIMIT - 32'd1) begin
      op = ocse_pkg::OP_BEQ;
      same_ab = 1'b1;
    end
    ra = 3'($urandom);
    rb = same_ab ? ra : 3'($urandom);
    ins = encode(ocse_pkg::OP_NOOP, ra, rb, 16'($urandom));
    found = 1'b0;
    case (op)
      ocse_pkg::OP_LW, ocse_pkg::OP_SW: begin
        for (int i = 0; i < 32 && !found; i++) begin
          ra = 3'($urandom);
          off = pick_offset();
          dest = arch_regs[ra] + {{16{off[15]}}, off};
          found = reachable(dest);
        end
        if (found) ins = encode(op, ra, rb, off);
      end
      ocse_pkg::OP_BEQ: begin
        off = 16'($urandom);
        if (arch_regs[ra] == arch_regs[rb]) begin
          for (int i = 0; i < 32 && !found; i++) begin
            off = pick_offset();
            dest = arch_pc + 32'd1 + {{16{off[15]}}, off};
            found = reachable(dest);
          end
          if (!found) off = 16'hffff;
        end
        ins = encode(ocse_pkg::OP_BEQ, ra, rb, off);
      end
      ocse_pkg::OP_JALR: begin
        if (!same_ab) begin
          for (int i = 0; i < 16 && !found; i++) begin
            ra = 3'($urandom);
            found = reachable(arch_regs[ra]);
          end
          if (!found) rb = ra;
        end
        ins = encode(ocse_pkg::OP_JALR, ra, rb, 16'($urandom));
      end
      default: ins = encode(op, ra, rb, 16'($urandom));
    endcase
  endtask

  // instruction that ends the run: halt, a data fault, or a jump off the memory
  task automatic build_stop(output logic [31:0] ins);
    logic [2:0]  ra;
    logic [15:0] off;
    logic [31:0] dest;
    bit          found;
    found = 1'b0;
    ins = encode(ocse_pkg::OP_HALT, 3'($urandom), 3'($urandom), 16'($urandom));
    case ($urandom_range(0, 2))
      1: begin
        for (int i = 0; i < 64 && !found; i++) begin
          ra = 3'($urandom);
          off = pick_offset();
          dest = arch_regs[ra] + {{16{off[15]}}, off};
          found = !reachable(dest);
        end
        if (found) begin
          ins = encode(($urandom_range(0, 1) == 1) ? ocse_pkg::OP_LW : ocse_pkg::OP_SW,
                       ra, 3'($urandom), off);
        end
      end
      2: begin
        for (int r = 0; r < ocse_pkg::REG_COUNT && !found; r++) begin
          if (!reachable(arch_regs[r])) begin
            found = 1'b1;
            ins = encode(ocse_pkg::OP_JALR, 3'(r), 3'(r + 1), 16'($urandom));
          end
        end
        for (int i = 0; i < 2 && !found; i++) begin
          off = (i == 0) ? 16'h8000 : 16'h7fff;
          dest = arch_pc + 32'd1 + {{16{off[15]}}, off};
          if (!reachable(dest)) begin
            found = 1'b1;
            ra = 3'($urandom);
            ins = encode(ocse_pkg::OP_BEQ, ra, ra, off);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic run_instr(input logic [31:0] ins);
    send(ocse_pkg::KIND_LOAD, arch_pc[15:0], ins);
    send(ocse_pkg::KIND_STEP, 16'($urandom), $urandom);
  endtask

  // result side, with one long hold-off so the block backs up
  initial begin
    int pops;
    int gap;
    bit calm;
    pop = 1'b0;
    pops = 0;
    calm = 1'b0;
    @(negedge clk);
    forever begin
      if (pops % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      gap = calm ? 0 : $urandom_range(0, 16);
      if (pops == 300) gap = 600;
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
      pops++;
    end
  end

  initial begin
    ocse_pkg::op_t plan [10];
    bit            plan_same [10];
    logic [31:0]   ins;
    logic [15:0]   other;
    ocse_pkg::op_t op;
    int            pick;
    plan = '{ocse_pkg::OP_ADD, ocse_pkg::OP_NOR, ocse_pkg::OP_LW, ocse_pkg::OP_SW,
             ocse_pkg::OP_BEQ, ocse_pkg::OP_BEQ, ocse_pkg::OP_JALR, ocse_pkg::OP_JALR,
             ocse_pkg::OP_NOOP, ocse_pkg::OP_LW};
    plan_same = '{0, 0, 0, 0, 1, 0, 1, 0, 0, 0};
    beats_sent = 0;
    send_calm = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    cmd = ocse_pkg::KIND_LOAD;
    load_address = '0;
    load_word = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // cleared memory first, then the field extremes and each opcode
    send(ocse_pkg::KIND_STEP, 16'h0000, 32'h0000_0000);
    send(ocse_pkg::KIND_LOAD, 16'hffff, 32'hffff_ffff);
    send(ocse_pkg::KIND_LOAD, 16'h0000, 32'h0000_0000);
    for (int i = 0; i < 10; i++) begin
      build_instr(plan[i], plan_same[i], ins);
      run_instr(ins);
    end

    while (beats_sent < RANDOM_BEATS + 23) begin
      pick = $urandom_range(0, 99);
      op = ocse_pkg::op_t'($urandom_range(0, 7));
      if (op == ocse_pkg::OP_HALT) op = ocse_pkg::OP_JALR;
      build_instr(op, $urandom_range(0, 3) == 0, ins);
      if (pick < 70) begin
        run_instr(ins);
      end else if (pick < 85) begin
        send(ocse_pkg::KIND_LOAD, 16'($urandom), pick_data());
      end else begin
        // data beat slipped between the instruction load and its step
        send(ocse_pkg::KIND_LOAD, arch_pc[15:0], ins);
        other = 16'($urandom);
        if (other == arch_pc[15:0]) other = other + 16'd1;
        send(ocse_pkg::KIND_LOAD, other, pick_data());
        send(ocse_pkg::KIND_STEP, 16'($urandom), $urandom);
      end
    end

    build_stop(ins);
    run_instr(ins);
    for (int i = 0; i < 6; i++) begin
      send((i % 2 == 0) ? ocse_pkg::KIND_STEP : ocse_pkg::KIND_LOAD, 16'($urandom),
           $urandom);
    end
    push = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("** eight_op_cpu_step_engine_unit: PASSED **");
    end else begin
      $display("** eight_op_cpu_step_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule
